FILE: rtl/bpf_pkg.sv
// shared types, constants and helpers for the bootloader packet framer
`default_nettype none
package bpf_pkg;

    localparam int unsigned CfgIndexWidth = 2;
    localparam int unsigned QueueDepth    = 2;
    localparam int unsigned QueueAw       = $clog2(QueueDepth);

    localparam logic [CfgIndexWidth-1:0] CFG_START  = 2'd0;
    localparam logic [CfgIndexWidth-1:0] CFG_END    = 2'd1;
    localparam logic [CfgIndexWidth-1:0] CFG_ESCAPE = 2'd2;

    localparam logic [7:0] START_RESET  = 8'd15;
    localparam logic [7:0] END_RESET    = 8'd4;
    localparam logic [7:0] ESCAPE_RESET = 8'd5;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       last_of_packet;
    } in_t;

    typedef struct packed {
        logic [7:0] line_byte;
        logic       frame_end;
        logic       run_last;
    } out_t;

    typedef struct packed {
        logic [7:0] start_byte;
        logic [7:0] end_byte;
        logic [7:0] escape_byte;
    } cfg_t;

    // one classified payload byte
    typedef struct packed {
        logic [7:0] data;
        logic [7:0] sum;
        logic       open;
        logic       last;
        logic       esc_data;
        logic       esc_sum;
    } cmd_t;

    typedef enum logic [6:0] {
        ST_START1 = 7'b0000001,
        ST_START2 = 7'b0000010,
        ST_ESC_D  = 7'b0000100,
        ST_DATA   = 7'b0001000,
        ST_ESC_S  = 7'b0010000,
        ST_SUM    = 7'b0100000,
        ST_END    = 7'b1000000
    } step_t;

    function automatic logic is_special(input cfg_t cfg, input logic [7:0] b);
        return (b == cfg.start_byte) || (b == cfg.end_byte) || (b == cfg.escape_byte);
    endfunction

endpackage
`default_nettype wire

FILE: rtl/bootloader_packet_framer_top.sv
// top level of the bootloader packet framer
`default_nettype none
// Framer for a serial bootloader link. Each payload byte transaction produces
// one line byte per clock cycle unless line_ready stalls it: 1 or 2 bytes for
// a mid-packet byte (the byte, with an escape byte ahead of it when special),
// plus 2 start bytes on the first byte of a packet and 2 to 3 bytes (checksum,
// its escape, end byte) on the last, so 1 to 7 line bytes per transaction. The
// back end sequencer loads its output register with one line byte a cycle when
// not stalled. The front end classifies bytes into a two-entry queue and keeps
// accepting while the back end works, until the queue is full. Configuration
// writes are always accepted; the user must see that they are made while no
// transaction is in flight, as the block does not enforce it. An index beyond the escape byte is ignored.
module bootloader_packet_framer_top (
    input  wire  logic                              clk,
    input  wire  logic                              rst_n,
    input  wire  logic                              cfg_valid,
    output       logic                              cfg_ready,
    input  wire  logic [bpf_pkg::CfgIndexWidth-1:0] cfg_index,
    input  wire  logic [7:0]                        cfg_data,
    input  wire  logic                              byte_valid,
    output       logic                              byte_ready,
    input  wire  bpf_pkg::in_t                      byte_data,
    output       logic                              line_valid,
    input  wire  logic                              line_ready,
    output       bpf_pkg::out_t                     line_data
);

    bpf_pkg::cfg_t cfg;
    bpf_pkg::cmd_t push_cmd;
    bpf_pkg::cmd_t head;
    logic          push;
    logic          pop;
    logic          queue_full;
    logic          head_valid;

    bpf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_data  (byte_data),
        .queue_full (queue_full),
        .push       (push),
        .push_cmd   (push_cmd),
        .cfg        (cfg)
    );

    bpf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (queue_full),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid)
    );

    bpf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .line_valid (line_valid),
        .line_ready (line_ready),
        .line_data  (line_data)
    );

endmodule
`default_nettype wire

FILE: rtl/bpf_front.sv
// front end: configuration registers, checksum and byte classification
`default_nettype none
module bpf_front (
    input  wire  logic                                 clk,
    input  wire  logic                                 rst_n,
    input  wire  logic                                 cfg_valid,
    output       logic                                 cfg_ready,
    input  wire  logic [bpf_pkg::CfgIndexWidth-1:0]    cfg_index,
    input  wire  logic [7:0]                           cfg_data,
    input  wire  logic                                 byte_valid,
    output       logic                                 byte_ready,
    input  wire  bpf_pkg::in_t                         byte_data,
    input  wire  logic                                 queue_full,
    output       logic                                 push,
    output       bpf_pkg::cmd_t                        push_cmd,
    output       bpf_pkg::cfg_t                        cfg
);

    bpf_pkg::cfg_t cfg_reg, cfg_next;
    logic          inside_reg, inside_next;
    logic [7:0]    sum_reg, sum_next;
    logic [7:0]    sum_new;

    assign cfg_ready  = 1'b1;
    assign byte_ready = !queue_full;
    assign push       = byte_valid && byte_ready;
    assign cfg        = cfg_reg;
    assign sum_new    = sum_reg - byte_data.payload_byte;

    always_comb
    begin
        push_cmd.data     = byte_data.payload_byte;
        push_cmd.sum      = sum_new;
        push_cmd.open     = !inside_reg;
        push_cmd.last     = byte_data.last_of_packet;
        push_cmd.esc_data = bpf_pkg::is_special(cfg_reg, byte_data.payload_byte);
        push_cmd.esc_sum  = bpf_pkg::is_special(cfg_reg, sum_new);
    end

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                bpf_pkg::CFG_START:  cfg_next.start_byte  = cfg_data;
                bpf_pkg::CFG_END:    cfg_next.end_byte    = cfg_data;
                bpf_pkg::CFG_ESCAPE: cfg_next.escape_byte = cfg_data;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        inside_next = inside_reg;
        sum_next    = sum_reg;
        if (push)
        begin
            inside_next = !byte_data.last_of_packet;
            sum_next    = byte_data.last_of_packet ? 8'd0 : sum_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_byte  <= bpf_pkg::START_RESET;
            cfg_reg.end_byte    <= bpf_pkg::END_RESET;
            cfg_reg.escape_byte <= bpf_pkg::ESCAPE_RESET;
            inside_reg          <= 1'b0;
            sum_reg             <= 8'd0;
        end
        else
        begin
            cfg_reg    <= cfg_next;
            inside_reg <= inside_next;
            sum_reg    <= sum_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/bpf_queue.sv
// short command queue between front and back ends
`default_nettype none
module bpf_queue (
    input  wire  logic          clk,
    input  wire  logic          rst_n,
    input  wire  logic          push,
    input  wire  bpf_pkg::cmd_t push_cmd,
    output       logic          full,
    input  wire  logic          pop,
    output       bpf_pkg::cmd_t head,
    output       logic          head_valid
);

    bpf_pkg::cmd_t                 entry_reg [bpf_pkg::QueueDepth];
    logic [bpf_pkg::QueueAw-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [bpf_pkg::QueueAw-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [bpf_pkg::QueueAw:0]     count_reg, count_next;

    assign full       = (count_reg == (bpf_pkg::QueueAw+1)'(bpf_pkg::QueueDepth));
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule
`default_nettype wire

FILE: rtl/bpf_back.sv
// back end: line byte sequencer and output register
`default_nettype none
module bpf_back (
    input  wire  logic          clk,
    input  wire  logic          rst_n,
    input  wire  bpf_pkg::cfg_t cfg,
    input  wire  bpf_pkg::cmd_t head,
    input  wire  logic          head_valid,
    output       logic          pop,
    output       logic          line_valid,
    input  wire  logic          line_ready,
    output       bpf_pkg::out_t line_data
);

    bpf_pkg::step_t step_reg, step_next;
    logic           fresh_reg, fresh_next;
    logic           out_valid_reg, out_valid_next;
    bpf_pkg::out_t  out_reg, out_next;
    bpf_pkg::step_t cur_step;
    bpf_pkg::step_t follow_step;
    logic           done;
    logic           advance;

    assign line_valid = out_valid_reg;
    assign line_data  = out_reg;
    assign advance    = head_valid && (!out_valid_reg || line_ready);
    assign pop        = advance && done;

    always_comb
    begin
        if (!fresh_reg)
            cur_step = step_reg;
        else if (head.open)
            cur_step = bpf_pkg::ST_START1;
        else if (head.esc_data)
            cur_step = bpf_pkg::ST_ESC_D;
        else
            cur_step = bpf_pkg::ST_DATA;
    end

    always_comb
    begin
        follow_step        = bpf_pkg::ST_DATA;
        done               = 1'b0;
        out_next.line_byte = head.data;
        out_next.frame_end = 1'b0;
        unique case (cur_step)
            bpf_pkg::ST_START1:
            begin
                out_next.line_byte = cfg.start_byte;
                follow_step        = bpf_pkg::ST_START2;
            end
            bpf_pkg::ST_START2:
            begin
                out_next.line_byte = cfg.start_byte;
                follow_step        = head.esc_data ? bpf_pkg::ST_ESC_D : bpf_pkg::ST_DATA;
            end
            bpf_pkg::ST_ESC_D:
            begin
                out_next.line_byte = cfg.escape_byte;
                follow_step        = bpf_pkg::ST_DATA;
            end
            bpf_pkg::ST_DATA:
            begin
                out_next.line_byte = head.data;
                follow_step        = head.esc_sum ? bpf_pkg::ST_ESC_S : bpf_pkg::ST_SUM;
                done               = !head.last;
            end
            bpf_pkg::ST_ESC_S:
            begin
                out_next.line_byte = cfg.escape_byte;
                follow_step        = bpf_pkg::ST_SUM;
            end
            bpf_pkg::ST_SUM:
            begin
                out_next.line_byte = head.sum;
                follow_step        = bpf_pkg::ST_END;
            end
            bpf_pkg::ST_END:
            begin
                out_next.line_byte = cfg.end_byte;
                out_next.frame_end = 1'b1;
                done               = 1'b1;
            end
            default:
            begin
                out_next.line_byte = head.data;
                done               = 1'b1;
            end
        endcase
        out_next.run_last = done;
    end

    always_comb
    begin
        step_next      = step_reg;
        fresh_next     = fresh_reg;
        out_valid_next = out_valid_reg && !line_ready;
        if (advance)
        begin
            out_valid_next = 1'b1;
            fresh_next     = done;
            step_next      = follow_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= bpf_pkg::ST_START1;
            fresh_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            fresh_reg     <= fresh_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= out_next;
    end

endmodule
`default_nettype wire

FILE: verif/bootloader_packet_framer_top_tb.sv
// testbench for the bootloader packet framer: a directed script, then random packets
module bootloader_packet_framer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [bpf_pkg::CfgIndexWidth-1:0] CFG_SPARE = 2'd3;
    localparam int RandomPhases = 5;
    localparam int PhaseBytes   = 23;
    localparam int HoldCycles   = 150;

    typedef enum logic {ROW_CFG, ROW_BYTE} row_kind_t;
    typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_SPARSE, RX_CHOPPY} rx_mode_t;

    typedef struct {
        row_kind_t                         kind;
        logic [bpf_pkg::CfgIndexWidth-1:0] index;
        logic [7:0]                        value;
        bpf_pkg::in_t                      item;
        int                                typed;
    } script_row_t;

    // hand-worked framing for the simple rows of the script
    localparam bpf_pkg::out_t TYPED_LINES [31] = '{
        {8'h0F, 1'b0, 1'b0}, {8'h0F, 1'b0, 1'b0}, {8'h00, 1'b0, 1'b0},
        {8'h00, 1'b0, 1'b0}, {8'h04, 1'b1, 1'b1},
        {8'h0F, 1'b0, 1'b0}, {8'h0F, 1'b0, 1'b0}, {8'hFF, 1'b0, 1'b1},
        {8'h05, 1'b0, 1'b0}, {8'h0F, 1'b0, 1'b0}, {8'hF2, 1'b0, 1'b0},
        {8'h04, 1'b1, 1'b1},
        {8'h0F, 1'b0, 1'b0}, {8'h0F, 1'b0, 1'b0}, {8'hFB, 1'b0, 1'b0},
        {8'h05, 1'b0, 1'b0}, {8'h05, 1'b0, 1'b0}, {8'h04, 1'b1, 1'b1},
        {8'h80, 1'b0, 1'b0}, {8'h80, 1'b0, 1'b0}, {8'hFF, 1'b0, 1'b0},
        {8'h80, 1'b0, 1'b0}, {8'hFF, 1'b0, 1'b0}, {8'h80, 1'b0, 1'b0},
        {8'h00, 1'b1, 1'b1},
        {8'h80, 1'b0, 1'b0}, {8'h80, 1'b0, 1'b0}, {8'hFF, 1'b0, 1'b0},
        {8'h00, 1'b0, 1'b1},
        {8'hFF, 1'b0, 1'b0}, {8'hFF, 1'b0, 1'b1}
    };

    logic                              clk = 1'b0;
    logic                              rst_n;
    logic                              cfg_valid;
    logic                              cfg_ready;
    logic [bpf_pkg::CfgIndexWidth-1:0] cfg_index;
    logic [7:0]                        cfg_data;
    logic                              byte_valid;
    logic                              byte_ready;
    bpf_pkg::in_t                      byte_data;
    logic                              line_valid;
    logic                              line_ready;
    bpf_pkg::out_t                     line_data;

    bpf_pkg::cfg_t regs;
    logic [7:0]    frame_sum;
    logic          in_frame;
    bpf_pkg::out_t line_expect [$];
    bpf_pkg::out_t want_line;
    script_row_t   script [$];

    int unsigned mismatch_count = 0;
    int unsigned lines_seen = 0;
    int unsigned bytes_sent = 0;
    int unsigned packets_closed = 0;
    int unsigned settings_used = 0;
    int unsigned burst_left;
    int unsigned hold_gen = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;
    int unsigned rx_cycle = 0;
    rx_mode_t    rx_mode = RX_FREE;

    bootloader_packet_framer_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_data  (byte_data),
        .line_valid (line_valid),
        .line_ready (line_ready),
        .line_data  (line_data)
    );

    always #5 clk = ~clk;

    function automatic logic needs_escape(input logic [7:0] b);
        return b == regs.start_byte || b == regs.end_byte || b == regs.escape_byte;
    endfunction

    function automatic bpf_pkg::out_t line_of(input logic [7:0] b, input logic fend);
        bpf_pkg::out_t o;
        o.line_byte = b;
        o.frame_end = fend;
        o.run_last  = 1'b0;
        return o;
    endfunction

    function automatic void frame_payload_byte(input bpf_pkg::in_t it);
        bpf_pkg::out_t run [$];
        bpf_pkg::out_t o;
        if (!in_frame)
        begin
            run.push_back(line_of(regs.start_byte, 1'b0));
            run.push_back(line_of(regs.start_byte, 1'b0));
            in_frame = 1'b1;
        end
        frame_sum = frame_sum - it.payload_byte;
        if (needs_escape(it.payload_byte))
            run.push_back(line_of(regs.escape_byte, 1'b0));
        run.push_back(line_of(it.payload_byte, 1'b0));
        if (it.last_of_packet)
        begin
            if (needs_escape(frame_sum))
                run.push_back(line_of(regs.escape_byte, 1'b0));
            run.push_back(line_of(frame_sum, 1'b0));
            run.push_back(line_of(regs.end_byte, 1'b1));
            frame_sum = 8'h00;
            in_frame = 1'b0;
            packets_closed++;
        end
        o = run.pop_back();
        o.run_last = 1'b1;
        run.push_back(o);
        foreach (run[i])
            line_expect.push_back(run[i]);
    endfunction

    function automatic logic [7:0] pick_special();
        case ($urandom_range(0, 2))
            0: return regs.start_byte;
            1: return regs.end_byte;
            default: return regs.escape_byte;
        endcase
    endfunction

    function automatic logic [7:0] pick_reg_value();
        case ($urandom_range(0, 3))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic void add_cfg(input logic [bpf_pkg::CfgIndexWidth-1:0] idx,
                                    input logic [7:0] val);
        script_row_t r;
        r.kind  = ROW_CFG;
        r.index = idx;
        r.value = val;
        r.item  = '0;
        r.typed = 0;
        script.push_back(r);
    endfunction

    function automatic void add_byte(input logic [7:0] b, input logic last, input int typed);
        script_row_t r;
        r.kind  = ROW_BYTE;
        r.index = '0;
        r.value = '0;
        r.item.payload_byte   = b;
        r.item.last_of_packet = last;
        r.typed = typed;
        script.push_back(r);
    endfunction

    task automatic write_reg(input logic [bpf_pkg::CfgIndexWidth-1:0] idx,
                             input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            bpf_pkg::CFG_START:  regs.start_byte  = val;
            bpf_pkg::CFG_END:    regs.end_byte    = val;
            bpf_pkg::CFG_ESCAPE: regs.escape_byte = val;
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic offer_byte(input bpf_pkg::in_t it);
        byte_valid <= 1'b1;
        byte_data  <= it;
        do @(posedge clk); while (!byte_ready);
        bytes_sent++;
        burst_left--;
        if (burst_left == 0)
        begin
            byte_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 40);
        end
    endtask

    // idle the sender and let every outstanding line byte come out
    task automatic settle();
        byte_valid <= 1'b0;
        while (line_expect.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            line_ready <= 1'b0;
        else
        begin
            rx_cycle++;
            if (hold_seen != hold_gen)
            begin
                hold_seen = hold_gen;
                hold_left = HoldCycles;
            end
            if (rx_cycle % 64 == 0)
                rx_mode = rx_mode_t'($urandom_range(0, 3));
            if (hold_left != 0)
            begin
                hold_left--;
                line_ready <= 1'b0;
            end
            else
                case (rx_mode)
                    RX_FREE:   line_ready <= 1'b1;
                    RX_COIN:   line_ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: line_ready <= (rx_cycle % 5) != 0;
                    default:   line_ready <= (rx_cycle % 8) < 3;
                endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && line_valid && line_ready)
        begin
            lines_seen++;
            if (line_expect.size() == 0)
            begin
                $display("%0t: unexpected line byte, expected none, got %h", $time, line_data);
                mismatch_count++;
            end
            else
            begin
                want_line = line_expect.pop_front();
                if (line_data.line_byte !== want_line.line_byte)
                begin
                    $display("%0t: line_byte expected %h got %h",
                             $time, want_line.line_byte, line_data.line_byte);
                    mismatch_count++;
                end
                if (line_data.frame_end !== want_line.frame_end)
                begin
                    $display("%0t: frame_end expected %b got %b",
                             $time, want_line.frame_end, line_data.frame_end);
                    mismatch_count++;
                end
                if (line_data.run_last !== want_line.run_last)
                begin
                    $display("%0t: run_last expected %b got %b",
                             $time, want_line.run_last, line_data.run_last);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("timeout with %0d line bytes still expected", line_expect.size());
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        int           typed_pos;
        int           base;
        int           sent;
        int           plen;
        logic         last;
        logic  [7:0]  pay;
        logic  [7:0]  same;
        bpf_pkg::in_t it;

        rst_n      <= 1'b0;
        cfg_valid  <= 1'b0;
        cfg_index  <= '0;
        cfg_data   <= '0;
        byte_valid <= 1'b0;
        byte_data  <= '0;
        regs.start_byte  = bpf_pkg::START_RESET;
        regs.end_byte    = bpf_pkg::END_RESET;
        regs.escape_byte = bpf_pkg::ESCAPE_RESET;
        frame_sum  = 8'h00;
        in_frame   = 1'b0;
        typed_pos  = 0;
        burst_left = $urandom_range(1, 40);

        // reset values, then escaping of every special byte
        add_byte(8'h00, 1'b1, 5);
        add_byte(8'hFF, 1'b0, 3);
        add_byte(8'h0F, 1'b1, 4);
        add_byte(8'h04, 1'b0, 0);
        add_byte(8'h05, 1'b0, 0);
        add_byte(8'hAA, 1'b0, 0);
        add_byte(8'h55, 1'b1, 0);
        add_byte(8'hFB, 1'b1, 6);
        // one-byte packet with both byte and checksum escaped
        add_cfg(bpf_pkg::CFG_START, 8'h80);
        add_cfg(bpf_pkg::CFG_END, 8'h00);
        add_cfg(bpf_pkg::CFG_ESCAPE, 8'hFF);
        add_cfg(CFG_SPARE, 8'h5A);
        add_byte(8'h80, 1'b1, 7);
        add_byte(8'h00, 1'b0, 4);
        add_byte(8'hFF, 1'b0, 2);
        add_byte(8'h01, 1'b1, 0);
        // all three registers equal
        add_cfg(bpf_pkg::CFG_START, 8'h3C);
        add_cfg(bpf_pkg::CFG_END, 8'h3C);
        add_cfg(bpf_pkg::CFG_ESCAPE, 8'h3C);
        add_byte(8'h3C, 1'b1, 0);
        add_byte(8'hC4, 1'b1, 0);
        // change of end byte in the middle of a packet
        add_cfg(bpf_pkg::CFG_START, 8'hFF);
        add_cfg(bpf_pkg::CFG_END, 8'hFF);
        add_cfg(bpf_pkg::CFG_ESCAPE, 8'h00);
        add_byte(8'h7E, 1'b0, 0);
        add_cfg(bpf_pkg::CFG_END, 8'h7E);
        add_byte(8'h81, 1'b1, 0);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        settings_used = 1;
        foreach (script[i])
        begin
            if (script[i].kind == ROW_CFG)
            begin
                if (i == 0 || script[i - 1].kind != ROW_CFG)
                begin
                    settle();
                    settings_used++;
                end
                write_reg(script[i].index, script[i].value);
            end
            else
            begin
                base = line_expect.size();
                frame_payload_byte(script[i].item);
                if (script[i].typed != 0)
                begin
                    while (line_expect.size() > base)
                        void'(line_expect.pop_back());
                    repeat (script[i].typed)
                    begin
                        line_expect.push_back(TYPED_LINES[typed_pos]);
                        typed_pos++;
                    end
                end
                offer_byte(script[i].item);
            end
        end

        for (int ph = 0; ph < RandomPhases; ph++)
        begin
            settle();
            settings_used++;
            same = pick_reg_value();
            case (ph)
                0:
                begin
                    write_reg(bpf_pkg::CFG_START, 8'h00);
                    write_reg(bpf_pkg::CFG_END, 8'hFF);
                    write_reg(bpf_pkg::CFG_ESCAPE, pick_reg_value());
                end
                2:
                begin
                    write_reg(bpf_pkg::CFG_START, same);
                    write_reg(bpf_pkg::CFG_END, same);
                    write_reg(bpf_pkg::CFG_ESCAPE, same);
                end
                RandomPhases - 1:
                begin
                    write_reg(bpf_pkg::CFG_START, bpf_pkg::START_RESET);
                    write_reg(bpf_pkg::CFG_END, bpf_pkg::END_RESET);
                    write_reg(bpf_pkg::CFG_ESCAPE, bpf_pkg::ESCAPE_RESET);
                end
                default:
                begin
                    write_reg(bpf_pkg::CFG_START, pick_reg_value());
                    write_reg(bpf_pkg::CFG_END, pick_reg_value());
                    write_reg(bpf_pkg::CFG_ESCAPE, pick_reg_value());
                end
            endcase
            write_reg(CFG_SPARE, 8'($urandom));
            if (ph == 1)
                hold_gen++;
            sent = 0;
            while (sent < PhaseBytes)
            begin
                plen = $urandom_range(1, 8);
                for (int k = 0; k < plen && sent < PhaseBytes; k++)
                begin
                    last = (k == plen - 1);
                    if (last && $urandom_range(0, 3) == 0)
                        pay = frame_sum - pick_special();
                    else
                        case ($urandom_range(0, 9))
                            0, 1, 2: pay = pick_special();
                            3:       pay = 8'h00;
                            4:       pay = 8'hFF;
                            default: pay = 8'($urandom);
                        endcase
                    it.payload_byte   = pay;
                    it.last_of_packet = last;
                    frame_payload_byte(it);
                    offer_byte(it);
                    sent++;
                end
            end
        end

        settle();
        repeat (20) @(posedge clk);
        $display("sent %0d payload bytes closing %0d packets under %0d register settings",
                 bytes_sent, packets_closed, settings_used);
        $display("checked %0d line bytes, %0d mismatching fields", lines_seen, mismatch_count);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
